// ===== hw/rtl/fat_table_entry_engine_core_macros.svh =====
// Assertion shorthands for the table entry engine.
`ifndef FAT_TABLE_ENTRY_ENGINE_CORE_MACROS_SVH
`define FAT_TABLE_ENTRY_ENGINE_CORE_MACROS_SVH

// Same-cycle check, off while in reset.
`define FTE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent now, consequent in the next cycle, off while in reset.
`define FTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fte_pkg.sv =====
`default_nettype none

package fte_pkg;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_ALLOC = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] MODE_12   = 2'd0;
  localparam logic [1:0] MODE_16   = 2'd1;
  localparam logic [1:0] MODE_32   = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  // end-of-chain marker; the entry width trims it to 0xFF8 / 0xFFF8
  localparam logic [31:0] END_OF_CHAIN = 32'h0FFF_FFF8;

  typedef struct packed {
    logic [1:0] mode;
    logic       idx_odd;  // odd entry number: high 12 bits of the pair
    logic       w_odd;    // first word of the span sits in the odd bank
    logic [1:0] off;      // byte offset of the span in its first word
  } ent_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fat_table_entry_engine_core.sv =====
// File allocation table entry engine.
// Input channel (in_valid/in_ready) carries kind, cluster_index and entry_value;
// output channel (out_valid/out_ready) returns read_value, allocated_index and
// status, exactly one result per input transfer, in order.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 entry_mode, 1 cluster_count); write only while the engine is idle.
// The table lives in two 32-bit banks (even and odd words), so any entry span
// is one read of both banks and one write-back.
// Read and write: one bank read at the transfer, then one modify and write-back in
// EXEC, which also registers the result; the next item is taken back in IDLE.
// Allocate: the scan reads one entry per cycle from index 0; the first free entry
// found below cluster_count is written with END_OF_CHAIN and its index returned;
// with none free the status is STAT_FULL.
// Reset: the banks are swept to zero, one row per cycle, over all
// (TABLE_BYTES + 7) / 8 rows (2048 at the default size); in_ready stays low meanwhile.
// Stall: a result waiting on out_ready does not stop the next input transfer;
// the engine holds its following result until the output register empties.
`default_nettype none

`include "fat_table_entry_engine_core_macros.svh"

module fat_table_entry_engine_core #(
  parameter int TABLE_BYTES = 16384
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [13:0] cfg_data,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [13:0] cluster_index,
  input  wire logic [31:0] entry_value,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] read_value,
  output      logic [13:0] allocated_index,
  output      logic [1:0]  status
);

  localparam int ROWS  = (TABLE_BYTES + 7) / 8;
  localparam int ROW_W = $clog2(ROWS);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_HOLD  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [1:0]  entry_mode;
  logic [13:0] cluster_count;

  logic [ROW_W-1:0] clr_row;
  logic [13:0]      scan_idx;

  // item registers
  logic [1:0]       p_kind;
  logic [13:0]      p_idx;
  logic [31:0]      p_val;
  logic             p_w_odd;
  logic [1:0]       p_off;
  logic [ROW_W-1:0] p_row_e;
  logic [ROW_W-1:0] p_row_o;
  logic             p_fits;
  logic             p_vld;

  logic [31:0] hold_read;
  logic [13:0] hold_alloc;
  logic [1:0]  hold_stat;

  // span calculation for the index being issued
  logic [13:0]      iss_idx;
  logic [15:0]      base;
  logic             len4;
  logic [16:0]      span_end;
  logic             iss_fits;
  logic [13:0]      word;
  logic [13:0]      row_e14;
  logic [ROW_W-1:0] iss_row_e;
  logic [ROW_W-1:0] iss_row_o;

  logic             accept;
  logic             issue;
  logic             found;
  logic             exhausted;
  logic             wr_go;
  logic             slot_free;
  logic             res_go;
  logic [31:0]      res_read;
  logic [13:0]      res_alloc;
  logic [1:0]       res_stat;

  fte_pkg::ent_ctl_t dp_ctl;
  logic [31:0]      rd_even, rd_odd;
  logic [31:0]      dp_entry, dp_wr_even, dp_wr_odd;
  logic             dp_we_even, dp_we_odd;
  logic             ram_we_e, ram_we_o;
  logic [ROW_W-1:0] waddr_e, waddr_o;
  logic [31:0]      wdata_e, wdata_o;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign issue     = (state == ST_SCAN) && (scan_idx < cluster_count);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    iss_idx = (state == ST_SCAN) ? scan_idx : cluster_index;
    len4    = 1'b0;
    case (entry_mode)
      fte_pkg::MODE_12: base = 16'(iss_idx) + 16'(iss_idx[13:1]);
      fte_pkg::MODE_16: base = {1'b0, iss_idx, 1'b0};
      fte_pkg::MODE_32: begin
        base = {iss_idx, 2'b00};
        len4 = 1'b1;
      end
      default: base = 16'd0;
    endcase
  end

  assign span_end  = 17'(base) + (len4 ? 17'd4 : 17'd2);
  assign iss_fits  = 32'(span_end) <= 32'(TABLE_BYTES);
  assign word      = base[15:2];
  assign row_e14   = {1'b0, word[13:1]} + 14'(word[0]);
  assign iss_row_e = ROW_W'(row_e14);
  assign iss_row_o = ROW_W'(word[13:1]);

  assign dp_ctl = '{mode: entry_mode, idx_odd: p_idx[0], w_odd: p_w_odd, off: p_off};

  fte_entry_dp u_dp (
    .ctl     (dp_ctl),
    .wr_val  (p_val),
    .rd_even (rd_even),
    .rd_odd  (rd_odd),
    .entry   (dp_entry),
    .wr_even (dp_wr_even),
    .wr_odd  (dp_wr_odd),
    .we_even (dp_we_even),
    .we_odd  (dp_we_odd)
  );

  assign found     = (state == ST_SCAN) && p_vld && p_fits && (dp_entry == 32'd0);
  assign exhausted = (state == ST_SCAN) && !p_vld && !issue;
  assign wr_go     = found || ((state == ST_EXEC) && (p_kind == fte_pkg::KIND_WRITE) &&
                               (entry_mode != fte_pkg::MODE_NONE) && p_fits);

  assign ram_we_e = (state == ST_CLEAR) || (wr_go && dp_we_even);
  assign ram_we_o = (state == ST_CLEAR) || (wr_go && dp_we_odd);
  assign waddr_e  = (state == ST_CLEAR) ? clr_row : p_row_e;
  assign waddr_o  = (state == ST_CLEAR) ? clr_row : p_row_o;
  assign wdata_e  = (state == ST_CLEAR) ? 32'd0 : dp_wr_even;
  assign wdata_o  = (state == ST_CLEAR) ? 32'd0 : dp_wr_odd;

  fte_ram #(.WIDTH(32), .DEPTH(ROWS)) u_bank_even (
    .clk   (clk),
    .we    (ram_we_e),
    .waddr (waddr_e),
    .wdata (wdata_e),
    .raddr (iss_row_e),
    .rdata (rd_even)
  );

  fte_ram #(.WIDTH(32), .DEPTH(ROWS)) u_bank_odd (
    .clk   (clk),
    .we    (ram_we_o),
    .waddr (waddr_o),
    .wdata (wdata_o),
    .raddr (iss_row_o),
    .rdata (rd_odd)
  );

  always_comb begin
    res_go    = 1'b0;
    res_read  = 32'd0;
    res_alloc = 14'd0;
    res_stat  = fte_pkg::STAT_OK;
    case (state)
      ST_EXEC: begin
        res_go = 1'b1;
        case (p_kind)
          fte_pkg::KIND_READ: begin
            if (entry_mode != fte_pkg::MODE_NONE) begin
              if (!p_fits) begin
                res_stat = fte_pkg::STAT_RANGE;
              end else begin
                res_read = dp_entry;
              end
            end
          end
          fte_pkg::KIND_WRITE: begin
            if ((entry_mode != fte_pkg::MODE_NONE) && !p_fits) begin
              res_stat = fte_pkg::STAT_RANGE;
            end
          end
          fte_pkg::KIND_ALLOC: res_stat = fte_pkg::STAT_FULL;
          default: res_stat = fte_pkg::STAT_OK;
        endcase
      end
      ST_SCAN: begin
        if (found) begin
          res_go    = 1'b1;
          res_alloc = p_idx;
        end else if (exhausted) begin
          res_go   = 1'b1;
          res_stat = fte_pkg::STAT_FULL;
        end
      end
      ST_HOLD: begin
        res_go    = 1'b1;
        res_read  = hold_read;
        res_alloc = hold_alloc;
        res_stat  = hold_stat;
      end
      default: res_go = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_row == LAST_ROW) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          if ((kind == fte_pkg::KIND_ALLOC) && (entry_mode != fte_pkg::MODE_NONE)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_EXEC, ST_SCAN, ST_HOLD: begin
        if (res_go) begin
          state_next = slot_free ? ST_IDLE : ST_HOLD;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      entry_mode    <= fte_pkg::MODE_16;
      cluster_count <= 14'd0;
      clr_row       <= '0;
      scan_idx      <= 14'd0;
      p_vld         <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          fte_pkg::CFG_MODE:  entry_mode    <= cfg_data[1:0];
          fte_pkg::CFG_COUNT: cluster_count <= cfg_data;
          default: entry_mode <= entry_mode;
        endcase
      end
      if (state == ST_CLEAR) begin
        clr_row <= clr_row + 1'b1;
      end
      if (accept) begin
        scan_idx <= 14'd0;
        p_vld    <= 1'b0;
      end else if (state == ST_SCAN) begin
        p_vld <= issue;
        if (issue) begin
          scan_idx <= scan_idx + 14'd1;
        end
      end
      if (res_go && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_kind <= kind;
      p_val  <= (kind == fte_pkg::KIND_ALLOC) ? fte_pkg::END_OF_CHAIN : entry_value;
    end
    if (accept || issue) begin
      p_idx   <= iss_idx;
      p_w_odd <= word[0];
      p_off   <= base[1:0];
      p_row_e <= iss_row_e;
      p_row_o <= iss_row_o;
      p_fits  <= iss_fits;
    end
    if (res_go && !slot_free && (state != ST_HOLD)) begin
      hold_read  <= res_read;
      hold_alloc <= res_alloc;
      hold_stat  <= res_stat;
    end
    if (res_go && slot_free) begin
      read_value      <= res_read;
      allocated_index <= res_alloc;
      status          <= res_stat;
    end
  end

  `FTE_ASSERT(a_exec_write_only, ((state == ST_EXEC) && (ram_we_e || ram_we_o)) |-> (p_kind == fte_pkg::KIND_WRITE), "bank written by a non-write item")
  `FTE_ASSERT(a_hold_blocked, (state == ST_HOLD) |-> out_valid, "holding a result with the output register empty")
  `FTE_ASSERT_NEXT(a_accept_starts, accept, (state == ST_EXEC) || (state == ST_SCAN), "transfer did not start an operation")
  `FTE_ASSERT(a_clear_no_result, (state == ST_CLEAR) |-> !out_valid, "result during clear sweep")

endmodule

`default_nettype wire

// ===== hw/rtl/fte_ram.sv =====
`default_nettype none

module fte_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [AW-1:0]            waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [AW-1:0]            raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fte_entry_dp.sv =====
`default_nettype none

// Entry extract and merge over the two-word window read from the banks.
module fte_entry_dp (
  input  wire fte_pkg::ent_ctl_t ctl,
  input  wire logic [31:0]       wr_val,
  input  wire logic [31:0]       rd_even,
  input  wire logic [31:0]       rd_odd,
  output      logic [31:0]       entry,
  output      logic [31:0]       wr_even,
  output      logic [31:0]       wr_odd,
  output      logic              we_even,
  output      logic              we_odd
);

  logic [63:0] win;
  logic [63:0] sh;
  logic [15:0] v16;
  logic [31:0] new_ent;
  logic [7:0]  mask8;
  logic [63:0] bm;
  logic [63:0] put;
  logic [63:0] merged;
  logic [4:0]  shamt;

  assign shamt = {ctl.off, 3'b000};
  assign win   = ctl.w_odd ? {rd_even, rd_odd} : {rd_odd, rd_even};
  assign sh    = win >> shamt;
  assign v16   = sh[15:0];

  always_comb begin
    case (ctl.mode)
      fte_pkg::MODE_12: begin
        entry   = {20'd0, (ctl.idx_odd ? v16[15:4] : v16[11:0])};
        new_ent = {16'd0, (ctl.idx_odd ? {wr_val[11:0], v16[3:0]}
                                       : {v16[15:12], wr_val[11:0]})};
        mask8   = 8'h03 << ctl.off;
      end
      fte_pkg::MODE_16: begin
        entry   = {16'd0, v16};
        new_ent = {16'd0, wr_val[15:0]};
        mask8   = 8'h03 << ctl.off;
      end
      fte_pkg::MODE_32: begin
        entry   = sh[31:0];
        new_ent = wr_val;
        mask8   = 8'h0F << ctl.off;
      end
      default: begin
        entry   = 32'd0;
        new_ent = 32'd0;
        mask8   = 8'h00;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      bm[8*i +: 8] = {8{mask8[i]}};
    end
  end

  assign put    = {32'd0, new_ent} << shamt;
  assign merged = (win & ~bm) | (put & bm);

  assign wr_even = ctl.w_odd ? merged[63:32] : merged[31:0];
  assign wr_odd  = ctl.w_odd ? merged[31:0]  : merged[63:32];
  assign we_even = ctl.w_odd ? (|mask8[7:4]) : (|mask8[3:0]);
  assign we_odd  = ctl.w_odd ? (|mask8[3:0]) : (|mask8[7:4]);

endmodule

`default_nettype wire
